### sv/cle_pkg.sv
package cle_pkg;

  // Default line capacity
  localparam int LINE_LEN = 32;

  localparam int KEY_W  = 16;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 6;
  localparam int CFG_W  = 2;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Configuration register indexes
  typedef enum logic [CFG_W-1:0] {
    CFG_LEFT  = 2'd0,
    CFG_RIGHT = 2'd1,
    CFG_HOME  = 2'd2,
    CFG_END   = 2'd3
  } cfg_idx_e;

  localparam key_t LEFT_KEY_RST  = 16'd258;
  localparam key_t RIGHT_KEY_RST = 16'd259;
  localparam key_t HOME_KEY_RST  = 16'd260;
  localparam key_t END_KEY_RST   = 16'd261;

  // Fixed key codes and echo characters
  localparam key_t  KEY_BS       = 16'h0008;
  localparam key_t  KEY_DEL      = 16'h007F;
  localparam key_t  KEY_NL       = 16'h000A;
  localparam key_t  KEY_PRINT_LO = 16'h0020;
  localparam key_t  KEY_PRINT_HI = 16'h007E;
  localparam char_t CH_BS        = 8'h08;
  localparam char_t CH_NL        = 8'h0A;
  localparam char_t CH_SPACE     = 8'h20;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SAVE    = 2'd1,
    KIND_RESTORE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    KC_LEFT,
    KC_RIGHT,
    KC_HOME,
    KC_END,
    KC_BS,
    KC_DEL,
    KC_NL,
    KC_PRINT,
    KC_OTHER
  } key_class_e;

  // Echo character source
  typedef enum logic [1:0] {
    ES_KEY,
    ES_BS,
    ES_SPACE,
    ES_RD
  } esel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ONE,
    S_NONE,
    S_HOME,
    S_END,
    S_LEAD,
    S_SAVE,
    S_STREAM,
    S_TAIL,
    S_PAD,
    S_RESTORE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic  load_key;
    logic  start;
    logic  emit;
    kind_e kind;
    esel_e esel;
    logic  last;
    logic  step;
    logic  home_step;
    logic  tail_wr;
  } cle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    key_class_e cls;
    logic       c_gt0;
    logic       c_lt_n;
    logic       c_eq_n;
    logic       full;
    logic       last_step;
    logic       home_last;
    logic       idx_eq_end;
    logic       out_free;
  } cle_sts_t;

endpackage

### sv/cle_datapath.sv
module cle_datapath #(
  parameter int LineLen = cle_pkg::LINE_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  cle_pkg::key_t       cfg_data_i,
  input  cle_pkg::key_t       key_i,
  input  cle_pkg::cle_cmd_t   cmd_i,
  output cle_pkg::cle_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output cle_pkg::char_t      echo_char_o,
  output logic                dropped_o,
  output cle_pkg::cnt_t       line_length_o,
  output cle_pkg::cnt_t       cursor_offset_o,
  output logic                last_o
);
  import cle_pkg::*;

  localparam int IW = $clog2(LineLen + 1);
  localparam int AW = $clog2(LineLen);
  localparam logic [IW-1:0] ONE  = IW'(1);
  localparam logic [IW-1:0] TWO  = IW'(2);
  localparam logic [IW-1:0] FULL = IW'(LineLen);

  key_t           key_regs_q [4];
  key_t           key_q;
  key_class_e     cls;
  logic [IW-1:0]  len_q, len_d, cur_q, cur_d;
  logic           dropped_q, dropped_d;
  logic [IW-1:0]  idx_q, end_q;
  char_t          carry_q;
  char_t          mem [LineLen];
  char_t          rd_q;
  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_idx, wr_idx;
  char_t          wr_data;
  logic [IW-1:0]  idx_nxt;
  logic           full, c_lt_n;
  char_t          sel_char;

  logic           ovalid_q;
  kind_e          okind_q;
  char_t          ochar_q;
  logic           odrop_q, olast_q;
  cnt_t           olen_q, ocur_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_regs_q[CFG_LEFT]  <= LEFT_KEY_RST;
      key_regs_q[CFG_RIGHT] <= RIGHT_KEY_RST;
      key_regs_q[CFG_HOME]  <= HOME_KEY_RST;
      key_regs_q[CFG_END]   <= END_KEY_RST;
    end else if (cfg_valid_i) begin
      key_regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= key_i;
    end
  end

  // Key decode, first match wins
  always_comb begin
    priority if (key_q == key_regs_q[CFG_LEFT])  cls = KC_LEFT;
    else if (key_q == key_regs_q[CFG_RIGHT])     cls = KC_RIGHT;
    else if (key_q == key_regs_q[CFG_HOME])      cls = KC_HOME;
    else if (key_q == key_regs_q[CFG_END])       cls = KC_END;
    else if (key_q == KEY_BS)                    cls = KC_BS;
    else if (key_q == KEY_DEL)                   cls = KC_DEL;
    else if (key_q == KEY_NL)                    cls = KC_NL;
    else if (key_q >= KEY_PRINT_LO && key_q <= KEY_PRINT_HI) cls = KC_PRINT;
    else                                         cls = KC_OTHER;
  end

  assign full    = (len_q == FULL);
  assign c_lt_n  = (cur_q < len_q);
  assign idx_nxt = idx_q + ONE;

  assign sts_o.cls        = cls;
  assign sts_o.c_gt0      = (cur_q != '0);
  assign sts_o.c_lt_n     = c_lt_n;
  assign sts_o.c_eq_n     = (cur_q == len_q);
  assign sts_o.full       = full;
  assign sts_o.last_step  = (idx_nxt == end_q);
  assign sts_o.home_last  = (idx_q == ONE);
  assign sts_o.idx_eq_end = (idx_q == end_q);
  assign sts_o.out_free   = !ovalid_q || !out_stall_i;

  // Line memory access per command
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = cur_q;
    wr_en   = 1'b0;
    wr_idx  = idx_q;
    wr_data = carry_q;
    if (cmd_i.start) begin
      unique case (cls)
        KC_RIGHT, KC_END, KC_BS: begin
          rd_en = c_lt_n;
        end
        KC_DEL: begin
          rd_idx = cur_q + ONE;
          rd_en  = (cur_q + ONE) < len_q;
        end
        KC_NL: begin
          wr_en   = !full;
          wr_idx  = len_q;
          wr_data = CH_NL;
        end
        KC_PRINT: begin
          if (!full && !c_lt_n) begin
            wr_en   = 1'b1;
            wr_idx  = len_q;
            wr_data = key_q[CHAR_W-1:0];
          end else begin
            rd_en = !full;
          end
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end else if (cmd_i.step) begin
      rd_en = (idx_nxt != end_q);
      unique case (cls)
        KC_BS, KC_DEL: begin
          // close the gap: entry i takes entry i+1
          wr_en   = 1'b1;
          wr_data = rd_q;
          rd_idx  = idx_q + TWO;
        end
        KC_PRINT: begin
          // open a gap: entry i takes the carried character
          wr_en  = 1'b1;
          rd_idx = idx_nxt;
        end
        default: begin
          rd_idx = idx_nxt;
        end
      endcase
    end else if (cmd_i.tail_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // Length, cursor and drop flag take their final values at start
  always_comb begin
    len_d     = len_q;
    cur_d     = cur_q;
    dropped_d = dropped_q;
    if (cmd_i.start) begin
      dropped_d = (cls == KC_NL || cls == KC_PRINT) && full;
      unique case (cls)
        KC_LEFT:  if (cur_q != '0) cur_d = cur_q - ONE;
        KC_RIGHT: if (c_lt_n) cur_d = cur_q + ONE;
        KC_HOME:  cur_d = '0;
        KC_END:   cur_d = len_q;
        KC_BS: begin
          if (cur_q != '0) begin
            cur_d = cur_q - ONE;
            len_d = len_q - ONE;
          end
        end
        KC_DEL:   if (c_lt_n) len_d = len_q - ONE;
        KC_NL: begin
          if (full) begin
            cur_d = len_q;
          end else begin
            cur_d = len_q + ONE;
            len_d = len_q + ONE;
          end
        end
        KC_PRINT: begin
          if (!full) begin
            cur_d = cur_q + ONE;
            len_d = len_q + ONE;
          end
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      cur_q     <= '0;
      dropped_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      cur_q     <= cur_d;
      dropped_q <= dropped_d;
    end
  end

  // Walk index, stop bound and carried character
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      carry_q <= key_q[CHAR_W-1:0];
      end_q   <= len_q;
      if (cls == KC_BS) begin
        idx_q <= cur_q - ONE;
        end_q <= len_q - ONE;
      end else if (cls == KC_DEL) begin
        idx_q <= cur_q;
        end_q <= len_q - ONE;
      end else begin
        idx_q <= cur_q;
      end
    end else if (cmd_i.step) begin
      idx_q   <= idx_nxt;
      carry_q <= rd_q;
    end else if (cmd_i.home_step) begin
      idx_q <= idx_q - ONE;
    end
  end

  always_comb begin
    unique case (cmd_i.esel)
      ES_KEY:   sel_char = key_q[CHAR_W-1:0];
      ES_BS:    sel_char = CH_BS;
      ES_SPACE: sel_char = CH_SPACE;
      ES_RD:    sel_char = rd_q;
      default:  sel_char = rd_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      okind_q <= cmd_i.kind;
      ochar_q <= (cmd_i.kind == KIND_CHAR) ? sel_char : '0;
      olast_q <= cmd_i.last;
      odrop_q <= dropped_q;
      olen_q  <= cnt_t'(len_q);
      ocur_q  <= cnt_t'(cur_q);
    end
  end

  assign out_valid_o     = ovalid_q;
  assign kind_o          = okind_q;
  assign echo_char_o     = ochar_q;
  assign dropped_o       = odrop_q;
  assign line_length_o   = olen_q;
  assign cursor_offset_o = ocur_q;
  assign last_o          = olast_q;

endmodule

### sv/cle_ctrl.sv
module cle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cle_pkg::cle_sts_t   sts_i,
  output cle_pkg::cle_cmd_t   cmd_o
);
  import cle_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        unique case (sts_i.cls)
          KC_LEFT:  state_d = sts_i.c_gt0 ? S_ONE : S_NONE;
          KC_RIGHT: state_d = sts_i.c_lt_n ? S_ONE : S_NONE;
          KC_HOME:  state_d = sts_i.c_gt0 ? S_HOME : S_NONE;
          KC_END:   state_d = sts_i.c_lt_n ? S_END : S_NONE;
          KC_BS:    state_d = sts_i.c_gt0 ? S_LEAD : S_NONE;
          KC_DEL:   state_d = sts_i.c_lt_n ? S_SAVE : S_NONE;
          KC_NL:    state_d = sts_i.full ? S_NONE : S_ONE;
          KC_PRINT: begin
            priority if (sts_i.full) state_d = S_NONE;
            else if (sts_i.c_eq_n)   state_d = S_ONE;
            else                     state_d = S_LEAD;
          end
          default:  state_d = S_NONE;
        endcase
      end
      S_ONE, S_NONE, S_RESTORE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_HOME: begin
        if (sts_i.out_free && sts_i.home_last) state_d = S_IDLE;
      end
      S_END: begin
        if (sts_i.out_free && sts_i.last_step) state_d = S_IDLE;
      end
      S_LEAD: begin
        if (sts_i.out_free) state_d = S_SAVE;
      end
      S_SAVE: begin
        if (sts_i.out_free) state_d = sts_i.idx_eq_end ? S_PAD : S_STREAM;
      end
      S_STREAM: begin
        if (sts_i.out_free && sts_i.last_step) begin
          state_d = (sts_i.cls == KC_PRINT) ? S_TAIL : S_PAD;
        end
      end
      S_TAIL: state_d = S_RESTORE;
      S_PAD: begin
        if (sts_i.out_free) state_d = S_RESTORE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.kind = KIND_CHAR;
    cmd_o.esel = ES_KEY;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE:  cmd_o.load_key = in_valid_i;
      S_START: cmd_o.start = 1'b1;
      S_ONE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.last = 1'b1;
        unique case (sts_i.cls)
          KC_LEFT:  cmd_o.esel = ES_BS;
          KC_RIGHT: cmd_o.esel = ES_RD;
          default:  cmd_o.esel = ES_KEY;
        endcase
      end
      S_NONE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = KIND_NONE;
        cmd_o.last = 1'b1;
      end
      S_HOME: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.home_step = sts_i.out_free;
        cmd_o.esel      = ES_BS;
        cmd_o.last      = sts_i.home_last;
      end
      S_END: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.step = sts_i.out_free;
        cmd_o.esel = ES_RD;
        cmd_o.last = sts_i.last_step;
      end
      S_LEAD: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.esel = (sts_i.cls == KC_BS) ? ES_BS : ES_KEY;
      end
      S_SAVE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = KIND_SAVE;
      end
      S_STREAM: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.step = sts_i.out_free;
        cmd_o.esel = ES_RD;
      end
      S_TAIL: cmd_o.tail_wr = 1'b1;
      S_PAD: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.esel = ES_SPACE;
      end
      S_RESTORE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = KIND_RESTORE;
        cmd_o.last = 1'b1;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

endmodule

### sv/console_line_editor.sv
// Console line editor: takes one key code per beat and edits a line of up to
// LineLen characters, answering each key with a run of echo beats (characters,
// save-cursor and restore-cursor markers, or one empty beat), the last flagged
// by last_o. Keys are taken one at a time: a key is loaded while idle, applied
// in a start step and then answered beat by beat, and an insert adds a tail
// step that writes back the carried character; the longest runs come from
// erases and inserts near the line start. The walk is paced by the line memory, with one
// read and one write port, which is read and rewritten one character per cycle
// while the tail is shifted and echoed. Output stalls simply hold the walk. Key
// codes for the cursor keys are set through the configuration port; the user
// must write them only while idle, which the block itself does not enforce.
module console_line_editor #(
  parameter int LineLen = cle_pkg::LINE_LEN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  cle_pkg::key_t   cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cle_pkg::key_t   key_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output cle_pkg::char_t  echo_char_o,
  output logic            dropped_o,
  output cle_pkg::cnt_t   line_length_o,
  output cle_pkg::cnt_t   cursor_offset_o,
  output logic            last_o
);
  import cle_pkg::*;

  cle_cmd_t cmd;
  cle_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cle_datapath #(
    .LineLen (LineLen)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .key_i           (key_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .echo_char_o     (echo_char_o),
    .dropped_o       (dropped_o),
    .line_length_o   (line_length_o),
    .cursor_offset_o (cursor_offset_o),
    .last_o          (last_o)
  );

endmodule

### test/console_line_editor_tb.sv
`timescale 1ns / 100ps

module console_line_editor_tb;
  import cle_pkg::*;

  // One character or marker of a key's echo, before the state fields are known
  typedef struct packed {
    kind_e kind;
    char_t ch;
  } echo_t;

  // One expected output beat
  typedef struct packed {
    kind_e kind;
    char_t ch;
    logic  dropped;
    cnt_t  len;
    cnt_t  cur;
    logic  last;
  } beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  key_t       cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  key_t       key_i       = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  char_t      echo_char_o;
  logic       dropped_o;
  cnt_t       line_length_o;
  cnt_t       cursor_offset_o;
  logic       last_o;

  // Line editor shadow state
  char_t line_buf [LINE_LEN];
  int    line_len = 0;
  int    cursor   = 0;
  key_t  key_code [4];
  logic  refused;

  echo_t run_beats [$];
  beat_t echo_expect [$];
  key_t  key_pending [$];
  key_t  directed_keys [26];

  int err_count  = 0;
  bit idle_on    = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  int beats_seen = 0;
  bit held_off   = 1'b0;

  console_line_editor #(
    .LineLen(LINE_LEN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .echo_char_o    (echo_char_o),
    .dropped_o      (dropped_o),
    .line_length_o  (line_length_o),
    .cursor_offset_o(cursor_offset_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int gap_cycles();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_echo(kind_e kind, char_t ch);
    echo_t e;
    e.kind = kind;
    e.ch   = ch;
    run_beats.push_back(e);
  endfunction

  // Save, reprint from cursor to end, optional blank over the erased cell, restore
  function automatic void echo_tail(bit pad);
    push_echo(KIND_SAVE, '0);
    for (int i = cursor; i < line_len; i++) push_echo(KIND_CHAR, line_buf[i]);
    if (pad) push_echo(KIND_CHAR, CH_SPACE);
    push_echo(KIND_RESTORE, '0);
  endfunction

  function automatic void shadow_insert(char_t ch);
    if (line_len >= LINE_LEN) begin
      refused = 1'b1;
      return;
    end
    push_echo(KIND_CHAR, ch);
    for (int i = line_len; i > cursor; i--) line_buf[i] = line_buf[i-1];
    line_buf[cursor] = ch;
    line_len++;
    cursor++;
    if (cursor < line_len) echo_tail(1'b0);
  endfunction

  function automatic void shadow_erase(bit at_cursor);
    if (at_cursor) begin
      if (cursor >= line_len) return;
    end else begin
      if (cursor == 0) return;
      cursor--;
      push_echo(KIND_CHAR, CH_BS);
    end
    line_len--;
    for (int i = cursor; i < line_len; i++) line_buf[i] = line_buf[i+1];
    echo_tail(1'b1);
  endfunction

  // Apply one key to the shadow line and queue the beats it should produce
  function automatic void edit_line(key_t k);
    beat_t b;
    run_beats.delete();
    refused = 1'b0;
    if (k == key_code[CFG_LEFT]) begin
      if (cursor > 0) begin
        push_echo(KIND_CHAR, CH_BS);
        cursor--;
      end
    end else if (k == key_code[CFG_RIGHT]) begin
      if (cursor < line_len) begin
        push_echo(KIND_CHAR, line_buf[cursor]);
        cursor++;
      end
    end else if (k == key_code[CFG_HOME]) begin
      while (cursor > 0) begin
        push_echo(KIND_CHAR, CH_BS);
        cursor--;
      end
    end else if (k == key_code[CFG_END]) begin
      while (cursor < line_len) begin
        push_echo(KIND_CHAR, line_buf[cursor]);
        cursor++;
      end
    end else if (k == KEY_BS) begin
      shadow_erase(1'b0);
    end else if (k == KEY_DEL) begin
      shadow_erase(1'b1);
    end else if (k == KEY_NL) begin
      // newline jumps to the end even when the append is refused
      cursor = line_len;
      shadow_insert(CH_NL);
    end else if (k >= KEY_PRINT_LO && k <= KEY_PRINT_HI) begin
      shadow_insert(k[7:0]);
    end
    if (run_beats.size() == 0) push_echo(KIND_NONE, '0);
    foreach (run_beats[i]) begin
      b.kind    = run_beats[i].kind;
      b.ch      = (run_beats[i].kind == KIND_CHAR) ? run_beats[i].ch : '0;
      b.dropped = refused;
      b.len     = cnt_t'(line_len);
      b.cur     = cnt_t'(cursor);
      b.last    = (i == run_beats.size() - 1);
      echo_expect.push_back(b);
    end
  endfunction

  // Key driver: one beat per accepted key, random gaps between keys
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) edit_line(key_i);
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (key_pending.size() != 0) begin
        in_valid_i <= 1'b1;
        key_i      <= key_pending.pop_front();
        gap_left   = gap_cycles();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Echo monitor and output stall generator
  always @(posedge clk_i) begin
    beat_t exp_b;
    if (out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (echo_expect.size() == 0) begin
        $error("unexpected echo beat: kind %0d char %h", kind_o, echo_char_o);
        err_count++;
      end else begin
        exp_b = echo_expect.pop_front();
        if (kind_o !== exp_b.kind) begin
          $error("kind: expected %0d, got %0d", exp_b.kind, kind_o);
          err_count++;
        end
        if (echo_char_o !== exp_b.ch) begin
          $error("echo_char: expected %h, got %h", exp_b.ch, echo_char_o);
          err_count++;
        end
        if (dropped_o !== exp_b.dropped) begin
          $error("dropped: expected %0d, got %0d", exp_b.dropped, dropped_o);
          err_count++;
        end
        if (line_length_o !== exp_b.len) begin
          $error("line_length: expected %0d, got %0d", exp_b.len, line_length_o);
          err_count++;
        end
        if (cursor_offset_o !== exp_b.cur) begin
          $error("cursor_offset: expected %0d, got %0d", exp_b.cur, cursor_offset_o);
          err_count++;
        end
        if (last_o !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, last_o);
          err_count++;
        end
      end
    end
    // one long hold-off so the editor backs up and stalls its key input
    if (!held_off && beats_seen >= 150) begin
      held_off   = 1'b1;
      stall_left = 300;
    end
    if (stall_left == 0) stall_left = gap_cycles();
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_key_code(cfg_idx_e idx, key_t code);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_code[idx] = code;
    cfg_valid_i <= 1'b0;
  endtask

  // Let every queued key go through and every echo beat come back
  task automatic wait_drained();
    while (key_pending.size() != 0 || in_valid_i || echo_expect.size() != 0)
      @(posedge clk_i);
    repeat (LINE_LEN + 8) @(posedge clk_i);
  endtask

  // Random typing with occasional erase bursts that walk the line back down
  task automatic run_random(int n);
    int   count;
    int   r;
    int   burst;
    key_t k;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        burst = $urandom_range(3, 15);
        key_pending.push_back(r < 4 ? key_code[CFG_HOME] : key_code[CFG_END]);
        repeat (burst) key_pending.push_back(r < 4 ? KEY_DEL : KEY_BS);
        count += burst + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40)      k = key_t'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI));
        else if (r < 50) k = KEY_BS;
        else if (r < 58) k = KEY_DEL;
        else if (r < 64) k = key_code[CFG_LEFT];
        else if (r < 70) k = key_code[CFG_RIGHT];
        else if (r < 73) k = key_code[CFG_HOME];
        else if (r < 76) k = key_code[CFG_END];
        else if (r < 80) k = KEY_NL;
        else             k = key_t'($urandom_range(0, 16'hFFFF));
        key_pending.push_back(k);
        count++;
      end
    end
  endtask

  initial begin
    key_code[CFG_LEFT]  = LEFT_KEY_RST;
    key_code[CFG_RIGHT] = RIGHT_KEY_RST;
    key_code[CFG_HOME]  = HOME_KEY_RST;
    key_code[CFG_END]   = END_KEY_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_key_code(CFG_LEFT, LEFT_KEY_RST);
    write_key_code(CFG_RIGHT, RIGHT_KEY_RST);
    write_key_code(CFG_HOME, HOME_KEY_RST);
    write_key_code(CFG_END, END_KEY_RST);

    // Silent keys on an empty line, codes around the printable range,
    // then mid-line insert and both erases, cursor sweeps and newline
    directed_keys = '{KEY_BS, KEY_DEL, LEFT_KEY_RST, RIGHT_KEY_RST, HOME_KEY_RST,
                      END_KEY_RST, 16'hFFFF, 16'h0000, 16'h001F, 16'h0080,
                      KEY_PRINT_LO, KEY_PRINT_HI, 16'h0061, 16'h0062,
                      LEFT_KEY_RST, LEFT_KEY_RST, 16'h0058, KEY_BS, KEY_DEL,
                      RIGHT_KEY_RST, HOME_KEY_RST, KEY_DEL, END_KEY_RST, KEY_NL,
                      LEFT_KEY_RST, KEY_NL};
    foreach (directed_keys[i]) key_pending.push_back(directed_keys[i]);
    wait_drained();

    // Fill the line past capacity, then random editing
    idle_on = 1'b1;
    repeat (34) key_pending.push_back(key_t'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
    key_pending.push_back(KEY_NL);
    run_random(40);
    wait_drained();

    // Extreme codes; home shadows backspace, end shadows a printable
    write_key_code(CFG_LEFT, 16'h0000);
    write_key_code(CFG_RIGHT, 16'hFFFF);
    write_key_code(CFG_HOME, KEY_BS);
    write_key_code(CFG_END, 16'h007A);
    run_random(45);
    wait_drained();

    // Left and right share a code (left wins), end shadows delete
    write_key_code(CFG_LEFT, 16'hFFFF);
    write_key_code(CFG_RIGHT, 16'hFFFF);
    write_key_code(CFG_HOME, 16'h0000);
    write_key_code(CFG_END, KEY_DEL);
    run_random(35);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### console_line_editor.f
sv/cle_pkg.sv
sv/cle_datapath.sv
sv/cle_ctrl.sv
sv/console_line_editor.sv
test/console_line_editor_tb.sv
